// ===== rtl/core/tga_pkg.sv =====
`default_nettype none
package tga_pkg;

   // result kinds
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_RUN    = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // error codes
   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_TYPE  = 2'd1;
   localparam logic [1:0] ERR_DEPTH = 2'd2;

   // image type codes in header byte 2
   localparam logic [7:0] IMG_TYPE_RAW = 8'd2;
   localparam logic [7:0] IMG_TYPE_RLE = 8'd10;

   // depth in bytes, from header byte 16 divided by eight
   localparam logic [4:0] DEPTH_3_BYTES = 5'd3;
   localparam logic [4:0] DEPTH_4_BYTES = 5'd4;

   // header byte positions
   localparam logic [4:0] HDR_ID_LEN    = 5'd0;
   localparam logic [4:0] HDR_TYPE      = 5'd2;
   localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
   localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
   localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
   localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
   localparam logic [4:0] HDR_DEPTH     = 5'd16;
   localparam logic [4:0] HDR_LAST      = 5'd17;

   // default depth of the queue between parser and run stage
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       file_start;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] width;
      logic [15:0] height;
      logic        has_alpha;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [7:0]  run_length;
      logic        last_of_image;
      logic [1:0]  error_code;
   } rsp_type;

   // one classified entry from the parser
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] width;
      logic [15:0] height;
      logic [31:0] pixel_count;
      logic        has_alpha;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [7:0]  run;
      logic [1:0]  error_code;
   } op_type;

endpackage
`default_nettype wire

// ===== rtl/core/tga_front.sv =====
`default_nettype none
module tga_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire tga_pkg::req_type req_data,
   input  wire logic            queue_full,
   output logic                 push,
   output tga_pkg::op_type      op
);
   import tga_pkg::*;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_IDSKIP,
      PH_RAW,
      PH_PKT_HDR,
      PH_PKT_DATA,
      PH_IGNORE
   } phase_type;

   phase_type       phase_ff, phase_in, phase_cur;
   logic [4:0]      hidx_ff, hidx_in, hidx_cur;
   logic [7:0]      id_skip_ff, id_skip_in;
   logic            rle_ff, rle_in;
   logic [15:0]     width_ff, width_in;
   logic [15:0]     height_ff, height_in;
   logic            four_ff, four_in;
   logic [7:0]      pkt_left_ff, pkt_left_in;
   logic            repeat_ff, repeat_in;
   logic [1:0]      bip_ff, bip_in, bip_cur;
   logic [2:0][7:0] pix_ff, pix_in;
   logic [31:0]     pixel_count;
   logic            accept;
   logic [7:0]      b;
   logic [1:0]      last_pos;
   logic            pixel_done;

   assign accept      = req_valid && !queue_full;
   assign b           = req_data.data_byte;
   assign pixel_count = 32'(width_ff) * 32'(height_ff);
   assign last_pos    = four_ff ? 2'd3 : 2'd2;

   always_comb begin
      phase_cur   = req_data.file_start ? PH_HEADER : phase_ff;
      hidx_cur    = req_data.file_start ? 5'd0 : hidx_ff;
      bip_cur     = req_data.file_start ? 2'd0 : bip_ff;
      phase_in    = phase_ff;
      hidx_in     = hidx_ff;
      bip_in      = bip_ff;
      id_skip_in  = id_skip_ff;
      rle_in      = rle_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      four_in     = four_ff;
      pkt_left_in = pkt_left_ff;
      repeat_in   = repeat_ff;
      pix_in      = pix_ff;
      pixel_done  = 1'b0;
      push        = 1'b0;
      op          = '0;
      op.has_alpha = four_ff;
      op.blue      = pix_ff[0];
      op.green     = pix_ff[1];
      op.red       = four_ff ? pix_ff[2] : b;
      op.alpha     = four_ff ? b : 8'd0;
      op.run       = 8'd1;

      if (accept) begin
         phase_in = phase_cur;
         hidx_in  = hidx_cur;
         bip_in   = bip_cur;
         unique case (phase_cur)
            PH_HEADER: begin
               hidx_in = hidx_cur + 5'd1;
               unique case (hidx_cur)
                  HDR_ID_LEN: id_skip_in = b;
                  HDR_TYPE: begin
                     if (b == IMG_TYPE_RAW) begin
                        rle_in = 1'b0;
                     end else if (b == IMG_TYPE_RLE) begin
                        rle_in = 1'b1;
                     end else begin
                        push          = 1'b1;
                        op            = '0;
                        op.kind       = KIND_ERROR;
                        op.error_code = ERR_TYPE;
                        phase_in      = PH_IGNORE;
                     end
                  end
                  HDR_WIDTH_LO:  width_in[7:0]   = b;
                  HDR_WIDTH_HI:  width_in[15:8]  = b;
                  HDR_HEIGHT_LO: height_in[7:0]  = b;
                  HDR_HEIGHT_HI: height_in[15:8] = b;
                  HDR_DEPTH: begin
                     if (b[7:3] == DEPTH_3_BYTES) begin
                        four_in = 1'b0;
                     end else if (b[7:3] == DEPTH_4_BYTES) begin
                        four_in = 1'b1;
                     end else begin
                        push          = 1'b1;
                        op            = '0;
                        op.kind       = KIND_ERROR;
                        op.error_code = ERR_DEPTH;
                        phase_in      = PH_IGNORE;
                     end
                  end
                  HDR_LAST: begin
                     push           = 1'b1;
                     op             = '0;
                     op.kind        = KIND_HEADER;
                     op.width       = width_ff;
                     op.height      = height_ff;
                     op.has_alpha   = four_ff;
                     op.pixel_count = pixel_count;
                     if (pixel_count == 32'd0) begin
                        phase_in = PH_IGNORE;
                     end else if (id_skip_ff != 8'd0) begin
                        phase_in = PH_IDSKIP;
                     end else begin
                        phase_in = rle_ff ? PH_PKT_HDR : PH_RAW;
                     end
                  end
                  default: ;
               endcase
            end
            PH_IDSKIP: begin
               id_skip_in = id_skip_ff - 8'd1;
               if (id_skip_ff == 8'd1) begin
                  phase_in = rle_ff ? PH_PKT_HDR : PH_RAW;
               end
            end
            PH_PKT_HDR: begin
               // both packet kinds count low seven bits plus one
               repeat_in   = b[7];
               pkt_left_in = {1'b0, b[6:0]} + 8'd1;
               phase_in    = PH_PKT_DATA;
            end
            PH_RAW, PH_PKT_DATA: begin
               if (bip_cur < last_pos) begin
                  pix_in[bip_cur] = b;
                  bip_in          = bip_cur + 2'd1;
               end else begin
                  pixel_done = 1'b1;
                  bip_in     = 2'd0;
               end
            end
            PH_IGNORE: ;
         endcase

         if (pixel_done) begin
            push    = 1'b1;
            op.kind = KIND_RUN;
            if (phase_cur == PH_PKT_DATA) begin
               if (repeat_ff) begin
                  op.run   = pkt_left_ff;
                  phase_in = PH_PKT_HDR;
               end else begin
                  pkt_left_in = pkt_left_ff - 8'd1;
                  if (pkt_left_ff == 8'd1) begin
                     phase_in = PH_PKT_HDR;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         hidx_ff  <= '0;
         bip_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         hidx_ff  <= hidx_in;
         bip_ff   <= bip_in;
      end
      id_skip_ff  <= id_skip_in;
      rle_ff      <= rle_in;
      width_ff    <= width_in;
      height_ff   <= height_in;
      four_ff     <= four_in;
      pkt_left_ff <= pkt_left_in;
      repeat_ff   <= repeat_in;
      pix_ff      <= pix_in;
   end

endmodule
`default_nettype wire

// ===== rtl/core/tga_fifo.sv =====
`default_nettype none
module tga_fifo #(
   parameter int DEPTH = tga_pkg::QUEUE_DEPTH
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire tga_pkg::op_type push_op,
   input  wire logic           pop,
   output tga_pkg::op_type     head_op,
   output logic                empty,
   output logic                full
);
   import tga_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   op_type             mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign empty   = (count_ff == CNT_W'(0));
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head_op = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/tga_back.sv =====
`default_nettype none
module tga_back (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire tga_pkg::op_type head_op,
   input  wire logic           queue_empty,
   output logic                pop,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output tga_pkg::rsp_type    rsp_data
);
   import tga_pkg::*;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic        active_ff, active_in;
   logic [31:0] pixels_left_ff, pixels_left_in;
   logic        out_free;
   logic        trunc;
   logic [7:0]  run_eff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pop       = !queue_empty && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a run never goes past the pixels still owed to the image
   assign trunc   = (32'(head_op.run) >= pixels_left_ff);
   assign run_eff = trunc ? pixels_left_ff[7:0] : head_op.run;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      active_in      = active_ff;
      pixels_left_in = pixels_left_ff;
      if (out_free) begin
         rsp_valid_in = 1'b0;
      end
      if (pop) begin
         rsp_data_in      = '0;
         rsp_data_in.kind = head_op.kind;
         unique case (head_op.kind)
            KIND_HEADER: begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.width         = head_op.width;
               rsp_data_in.height        = head_op.height;
               rsp_data_in.has_alpha     = head_op.has_alpha;
               rsp_data_in.last_of_image = (head_op.pixel_count == 32'd0);
               pixels_left_in            = head_op.pixel_count;
               active_in                 = (head_op.pixel_count != 32'd0);
            end
            KIND_ERROR: begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.error_code = head_op.error_code;
               active_in              = 1'b0;
            end
            KIND_RUN: begin
               if (active_ff) begin
                  rsp_valid_in              = 1'b1;
                  rsp_data_in.has_alpha     = head_op.has_alpha;
                  rsp_data_in.red           = head_op.red;
                  rsp_data_in.green         = head_op.green;
                  rsp_data_in.blue          = head_op.blue;
                  rsp_data_in.alpha         = head_op.alpha;
                  rsp_data_in.run_length    = run_eff;
                  rsp_data_in.last_of_image = trunc;
                  pixels_left_in            = pixels_left_ff - 32'(run_eff);
                  active_in                 = !trunc;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         active_ff      <= 1'b0;
         pixels_left_ff <= '0;
      end else begin
         rsp_valid_ff   <= rsp_valid_in;
         active_ff      <= active_in;
         pixels_left_ff <= pixels_left_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   a_active_has_pixels: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> pixels_left_ff != 32'd0)
      else $error("image active with no pixels left");

   a_run_length_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.kind == KIND_RUN |->
         rsp_data_ff.run_length != 8'd0 && rsp_data_ff.run_length <= 8'd128)
      else $error("run length out of range");

   a_error_stops_image: assert property (@(posedge clock) disable iff (reset)
      pop && head_op.kind == KIND_ERROR |=> !active_ff && rsp_valid_ff)
      else $error("error request did not end the image");

endmodule
`default_nettype wire

// ===== rtl/core/tga_rle_image_decoder.sv =====
// streaming targa decoder for true-color images, image type 2 (raw) and
// type 10 (run-length) at 24 or 32 bits per pixel. one file byte is taken
// per request; req_data.file_start on a byte restarts the parser with that
// byte as header byte 0. the block answers with one header result (width,
// height, alpha flag), then pixel runs with red and blue already swapped out
// of the stored bgr order: a raw pixel is a run of one, a repeat packet is a
// single run of up to 128. a packet reaching past the image end is cut there
// and that run carries last_of_image; bytes after the image, or after an
// error result, are dropped until the next file start. throughput is one
// byte per cycle while the queue is not full, set by the byte parser at the
// front, and a result passes through the queue write, then the output
// register. the queue between parser and run stage absorbs rsp_stall, so
// req_stall rises only once the queue fills.
`default_nettype none
module tga_rle_image_decoder #(
   parameter int QUEUE_DEPTH = tga_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire tga_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output tga_pkg::rsp_type      rsp_data
);
   import tga_pkg::*;

   // parser to queue
   logic   push;
   op_type push_op;

   // queue to run stage
   op_type head_op;
   logic   queue_empty;
   logic   queue_full;
   logic   pop;

   // requests are held off only while the queue is full
   assign req_stall = queue_full;

   // front: header parsing, id skip, packet headers, pixel gathering
   tga_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .op         (push_op)
   );

   // short queue between the two halves
   tga_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .head_op (head_op),
      .empty   (queue_empty),
      .full    (queue_full)
   );

   // back: pixel countdown, run clipping, output register
   tga_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_op     (head_op),
      .queue_empty (queue_empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire
